FILE: rtl/recd_pkg.sv
// Package for the rotary encoder and key click decoder.
// Holds the shared types, event codes and limits; no dependencies.
`timescale 1ns / 1ps

package recd_pkg;

    localparam int unsigned TickW = 14;

    // Press counter saturates here, the release gap counter at its full width.
    localparam logic [TickW-1:0] PressMax = 14'd10000;
    localparam logic [TickW-1:0] GapMax   = 14'd16383;

    // Scan event codes.
    localparam logic [1:0] EvNone = 2'd0;
    localparam logic [1:0] EvCw   = 2'd1;
    localparam logic [1:0] EvCcw  = 2'd2;
    localparam logic [1:0] EvKey  = 2'd3;

    // Double click progress codes.
    localparam logic [1:0] DblNone = 2'd0;
    localparam logic [1:0] DblSeen = 2'd1;
    localparam logic [1:0] DblDone = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] RegDetentMode  = 2'd0;
    localparam logic [1:0] RegDebounce    = 2'd1;
    localparam logic [1:0] RegLongPress   = 2'd2;
    localparam logic [1:0] RegDoubleClick = 2'd3;

    typedef struct packed {
        logic             detent_mode;
        logic [TickW-1:0] debounce_ticks;
        logic [TickW-1:0] long_press_ticks;
        logic [TickW-1:0] double_click_ticks;
    } cfg_t;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic key_level;
    } sample_t;

    typedef struct packed {
        logic valid;
        logic dir;
    } rot_t;

    typedef struct packed {
        logic             short_flag;
        logic             long_flag;
        logic [1:0]       double_flag;
        logic [TickW-1:0] press_ticks;
    } click_t;

endpackage

FILE: rtl/recd_if.sv
// Valid/ready channel interfaces for encoder samples and decoded results.
// Depends on recd_pkg for the tick counter width.
`timescale 1ns / 1ps

interface recd_in_if;
    logic valid;
    logic ready;
    logic pin_a;
    logic pin_b;
    logic key_level;

    modport source (output valid, output pin_a, output pin_b, output key_level, input ready);
    modport sink   (input valid, input pin_a, input pin_b, input key_level, output ready);
endinterface

interface recd_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  scan_event;
    logic                        rotate_valid;
    logic                        rotate_dir;
    logic                        short_click;
    logic                        long_click;
    logic [1:0]                  double_state;
    logic [recd_pkg::TickW-1:0]  held_ticks;

    modport source (output valid, output scan_event, output rotate_valid, output rotate_dir,
                    output short_click, output long_click, output double_state,
                    output held_ticks, input ready);
    modport sink   (input valid, input scan_event, input rotate_valid, input rotate_dir,
                    input short_click, input long_click, input double_state,
                    input held_ticks, output ready);
endinterface

FILE: rtl/recd_rotation.sv
// Quadrature step detection from channel A edges, judged against channel B.
// Depends on recd_pkg for the sample and rotation types.
`timescale 1ns / 1ps

module recd_rotation (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              detent_mode,
    input  recd_pkg::sample_t sample,
    output recd_pkg::rot_t    rot
);

    logic last_a_reg;
    logic a_changed;

    // In two-detent mode both edges of A count, otherwise only the falling one.
    assign a_changed = sample.pin_a != last_a_reg;
    assign rot.valid = a_changed && (detent_mode || !sample.pin_a);
    assign rot.dir   = rot.valid && (sample.pin_a ^ sample.pin_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg <= 1'b0;
        end
        else if (step)
        begin
            last_a_reg <= sample.pin_a;
        end
    end

endmodule

FILE: rtl/recd_click.sv
// Key press timing: press counter, release gap counter and click flags.
// Depends on recd_pkg for the configuration and click state types.
`timescale 1ns / 1ps

module recd_click (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             pressed,
    input  recd_pkg::cfg_t   cfg,
    output recd_pkg::click_t click_next
);

    logic [recd_pkg::TickW-1:0] press_reg;
    logic [recd_pkg::TickW-1:0] gap_reg;
    logic                       short_reg;
    logic                       long_reg;
    logic [1:0]                 double_reg;
    logic [recd_pkg::TickW-1:0] gap_next;
    logic [recd_pkg::TickW-1:0] press_inc;
    logic [recd_pkg::TickW-1:0] gap_inc;

    assign press_inc = (press_reg < recd_pkg::PressMax) ? press_reg + 14'd1 : press_reg;
    assign gap_inc   = (double_reg == recd_pkg::DblNone && gap_reg < recd_pkg::GapMax)
                       ? gap_reg + 14'd1 : gap_reg;

    always_comb
    begin
        click_next.press_ticks = press_reg;
        click_next.short_flag  = short_reg;
        click_next.long_flag   = long_reg;
        click_next.double_flag = double_reg;
        gap_next               = gap_reg;
        if (pressed)
        begin
            click_next.press_ticks = press_inc;
            if (press_inc == cfg.debounce_ticks)
            begin
                click_next.short_flag = 1'b1;
            end
            if (gap_reg != '0 && gap_reg <= cfg.double_click_ticks)
            begin
                click_next.double_flag = recd_pkg::DblSeen;
            end
            // A long press takes the place of the short click.
            if (press_inc == cfg.long_press_ticks)
            begin
                click_next.long_flag  = 1'b1;
                click_next.short_flag = 1'b0;
            end
        end
        else if (press_reg < cfg.debounce_ticks)
        begin
            // Release before debounce: treat as a bounce and start over.
            click_next.press_ticks = '0;
            click_next.short_flag  = 1'b0;
            click_next.long_flag   = 1'b0;
            click_next.double_flag = recd_pkg::DblNone;
            gap_next               = '0;
        end
        else if (short_reg)
        begin
            gap_next = gap_inc;
            if (double_reg == recd_pkg::DblSeen && gap_inc <= cfg.double_click_ticks)
            begin
                click_next.double_flag = recd_pkg::DblDone;
            end
            if (double_reg == recd_pkg::DblNone && gap_inc > cfg.double_click_ticks)
            begin
                click_next.short_flag = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_reg  <= '0;
            gap_reg    <= '0;
            short_reg  <= 1'b0;
            long_reg   <= 1'b0;
            double_reg <= recd_pkg::DblNone;
        end
        else if (step)
        begin
            press_reg  <= click_next.press_ticks;
            gap_reg    <= gap_next;
            short_reg  <= click_next.short_flag;
            long_reg   <= click_next.long_flag;
            double_reg <= click_next.double_flag;
        end
    end

endmodule

FILE: rtl/rotary_encoder_and_key_click_decoder.sv
// Rotary encoder and key click decoder, top level.
// An accepted sample item reaches its result item through two registers (input
// register, then result register); throughput one item per cycle while the result
// side takes results. Reset (rst_n, async, active low) empties both registers
// and returns all state and config to defaults.
`timescale 1ns / 1ps

module rotary_encoder_and_key_click_decoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [recd_pkg::TickW-1:0] cfg_data,
    recd_in_if.sink                    sample,
    recd_out_if.source                 result
);

    // Configuration registers. The user must write them only while the block is idle;
    // the block does not enforce it. Writes take effect directly, without shadowing.
    recd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detent_mode        <= 1'b1;
            cfg_reg.debounce_ticks     <= 14'd2;
            cfg_reg.long_press_ticks   <= 14'd100;
            cfg_reg.double_click_ticks <= 14'd30;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                recd_pkg::RegDetentMode:  cfg_reg.detent_mode        <= cfg_data[0];
                recd_pkg::RegDebounce:    cfg_reg.debounce_ticks     <= cfg_data;
                recd_pkg::RegLongPress:   cfg_reg.long_press_ticks   <= cfg_data;
                recd_pkg::RegDoubleClick: cfg_reg.double_click_ticks <= cfg_data;
                default:                  cfg_reg.detent_mode        <= cfg_reg.detent_mode;
            endcase
        end
    end

    // The input register takes a new item whenever it is empty or its current
    // item moves on in the same cycle. An item moves on when the result
    // register is empty or its item is being taken, so a waiting result that is
    // not taken stalls the input as soon as the input register holds an item.
    logic              in_vld_reg;
    recd_pkg::sample_t in_reg;
    logic              out_vld_reg;
    logic              advance;

    assign advance      = in_vld_reg && (!out_vld_reg || result.ready);
    assign sample.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_vld_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_reg.pin_a     <= sample.pin_a;
            in_reg.pin_b     <= sample.pin_b;
            in_reg.key_level <= sample.key_level;
        end
    end

    // The state of both decoders advances exactly when an item moves from the
    // input register into the result register.
    logic             pressed;
    recd_pkg::rot_t   rot;
    recd_pkg::click_t click_next;

    assign pressed = !in_reg.key_level;

    recd_rotation u_rotation (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .detent_mode (cfg_reg.detent_mode),
        .sample      (in_reg),
        .rot         (rot)
    );

    recd_click u_click (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .pressed    (pressed),
        .cfg        (cfg_reg),
        .click_next (click_next)
    );

    // A pressed key always reports a key event. In two-detent mode it also
    // hides the rotation step; in one-detent mode the step still shows on the
    // rotation outputs.
    logic [1:0] event_next;
    logic       rot_shown;

    assign rot_shown = rot.valid && !(pressed && cfg_reg.detent_mode);

    always_comb
    begin
        if (pressed)
        begin
            event_next = recd_pkg::EvKey;
        end
        else if (rot.valid)
        begin
            event_next = rot.dir ? recd_pkg::EvCw : recd_pkg::EvCcw;
        end
        else
        begin
            event_next = recd_pkg::EvNone;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || result.ready)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result.scan_event   <= event_next;
            result.rotate_valid <= rot_shown;
            result.rotate_dir   <= rot_shown && rot.dir;
            result.short_click  <= click_next.short_flag;
            result.long_click   <= click_next.long_flag;
            result.double_state <= click_next.double_flag;
            result.held_ticks   <= click_next.press_ticks;
        end
    end

    assign result.valid = out_vld_reg;

`ifndef SYNTHESIS
    // The press counter saturates and can never pass its ceiling.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> result.held_ticks <= recd_pkg::PressMax)
        else $error("held_ticks above saturation limit");

    // Double click progress only ever takes its three defined values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> result.double_state != 2'd3)
        else $error("double_state out of range");

    // A clockwise direction is only reported together with a rotation step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && result.rotate_dir) |-> result.rotate_valid)
        else $error("rotate_dir set without rotate_valid");

    // A key event in two-detent mode never carries a rotation step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && pressed && cfg_reg.detent_mode) |=> !result.rotate_valid)
        else $error("rotation reported under key press in two-detent mode");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the rotary encoder and key click decoder.
// Depends on recd_pkg, the recd_in_if / recd_out_if channel interfaces and the top level.
// Directed script first, then random press/release and knob phases, checked by a predictor.
`timescale 1ns / 1ps

module tb;

    // One decoded result item, laid out field by field as the result channel carries it.
    typedef struct packed {
        logic [1:0]                 scan_event;
        logic                       rotate_valid;
        logic                       rotate_dir;
        logic                       short_click;
        logic                       long_click;
        logic [1:0]                 double_state;
        logic [recd_pkg::TickW-1:0] held_ticks;
    } decode_t;

    // A script row either sends one sample item or writes one configuration register.
    typedef enum logic {RowItem, RowReg} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        recd_pkg::sample_t          pins;     // {pin_a, pin_b, key_level}, key low is pressed
        logic [1:0]                 reg_idx;
        logic [recd_pkg::TickW-1:0] reg_val;
        logic                       typed;    // the expected result below is used as written
        decode_t                    want;
    } script_row_t;

    localparam decode_t     NoWant      = '0;
    localparam int          NumRows     = 26;
    localparam int unsigned RandomItems = 1100;
    localparam int unsigned FinalItems  = 150;
    localparam int unsigned HoldCycles  = 120;
    localparam int unsigned CycleLimit  = 500000;

    // The directed script. It starts from the reset settings: two-detent mode, debounce 2,
    // long press 100, double click window 30. Rows marked typed carry a result that can be
    // read straight off the rules; all other rows are checked against the predictor.
    script_row_t script [NumRows] = '{
        // Idle knob right after reset: nothing to report, all flags clear.
        '{RowItem, 3'b001, recd_pkg::RegDetentMode, 14'd0, 1'b1,
          '{recd_pkg::EvNone, 1'b0, 1'b0, 1'b0, 1'b0, recd_pkg::DblNone, 14'd0}},
        // Rising A with B low is a clockwise step in two-detent mode.
        '{RowItem, 3'b101, recd_pkg::RegDetentMode, 14'd0, 1'b1,
          '{recd_pkg::EvCw, 1'b1, 1'b1, 1'b0, 1'b0, recd_pkg::DblNone, 14'd0}},
        // Falling A with B low is counter-clockwise.
        '{RowItem, 3'b001, recd_pkg::RegDetentMode, 14'd0, 1'b1,
          '{recd_pkg::EvCcw, 1'b1, 1'b0, 1'b0, 1'b0, recd_pkg::DblNone, 14'd0}},
        // Rising A with B high is counter-clockwise too.
        '{RowItem, 3'b111, recd_pkg::RegDetentMode, 14'd0, 1'b1,
          '{recd_pkg::EvCcw, 1'b1, 1'b0, 1'b0, 1'b0, recd_pkg::DblNone, 14'd0}},
        // Press without a knob move, then a falling A while pressed: the key wins and
        // the press reaches the debounce count, which raises the short click.
        '{RowItem, 3'b110, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        '{RowItem, 3'b010, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        // Release, press again inside the window, release: double click confirmed.
        '{RowItem, 3'b001, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        '{RowItem, 3'b000, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        '{RowItem, 3'b001, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        // One-detent mode: rising A is ignored, falling A is judged even while pressed.
        '{RowReg,  3'b000, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        '{RowItem, 3'b101, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        '{RowItem, 3'b000, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        '{RowItem, 3'b111, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        '{RowItem, 3'b011, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        // Debounce at the top of its width turns any release into an early release,
        // which clears every counter and flag.
        '{RowReg,  3'b000, recd_pkg::RegDebounce, 14'h3FFF, 1'b0, NoWant},
        '{RowItem, 3'b011, recd_pkg::RegDetentMode, 14'd0, 1'b1,
          '{recd_pkg::EvNone, 1'b0, 1'b0, 1'b0, 1'b0, recd_pkg::DblNone, 14'd0}},
        // Long press and debounce both at one: the long click replaces the short one at once.
        '{RowReg,  3'b000, recd_pkg::RegLongPress, 14'd1, 1'b0, NoWant},
        '{RowReg,  3'b000, recd_pkg::RegDebounce, 14'd1, 1'b0, NoWant},
        '{RowReg,  3'b000, recd_pkg::RegDoubleClick, 14'd0, 1'b0, NoWant},
        '{RowItem, 3'b010, recd_pkg::RegDetentMode, 14'd0, 1'b1,
          '{recd_pkg::EvKey, 1'b0, 1'b0, 1'b0, 1'b1, recd_pkg::DblNone, 14'd1}},
        '{RowItem, 3'b011, recd_pkg::RegDetentMode, 14'd0, 1'b1,
          '{recd_pkg::EvNone, 1'b0, 1'b0, 1'b0, 1'b1, recd_pkg::DblNone, 14'd1}},
        // Zero debounce never raises a short click and never counts as an early release.
        '{RowReg,  3'b000, recd_pkg::RegDebounce, 14'd0, 1'b0, NoWant},
        '{RowReg,  3'b000, recd_pkg::RegDetentMode, 14'd1, 1'b0, NoWant},
        '{RowItem, 3'b110, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        '{RowItem, 3'b001, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant},
        '{RowItem, 3'b100, recd_pkg::RegDetentMode, 14'd0, 1'b0, NoWant}
    };

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [1:0]                 cfg_index;
    logic [recd_pkg::TickW-1:0] cfg_data;

    recd_in_if  pins_ch ();
    recd_out_if decode_ch ();

    rotary_encoder_and_key_click_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (pins_ch),
        .result    (decode_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor copy of the settings and the decoder state, both at their reset values.
    recd_pkg::cfg_t             settings = '{1'b1, 14'd2, 14'd100, 14'd30};
    logic                       knob_last_a = 1'b0;
    logic                       knob_last_b = 1'b0;
    logic [recd_pkg::TickW-1:0] press_count = '0;
    logic [recd_pkg::TickW-1:0] gap_count = '0;
    logic                       short_seen = 1'b0;
    logic                       long_seen = 1'b0;
    logic [1:0]                 double_seen = recd_pkg::DblNone;

    // Results still owed by the decoder, oldest first.
    decode_t          pending_decodes [$];

    int unsigned      mismatches = 0;
    int unsigned      results_seen = 0;
    int unsigned      cycle_count = 0;
    bit               steady = 1'b0;   // both sides stop idling while this is set
    bit               hold_now = 1'b0; // the result side starts its long hold-off

    // Knob position along the Gray sequence 00, 01, 11, 10 of (A, B), and its direction.
    logic [1:0]       knob_pos = 2'd0;
    logic             knob_cw = 1'b1;

    // Works out the result of one scan tick and advances the predictor state.
    function automatic decode_t decode_tick(input recd_pkg::sample_t s);
        decode_t d;
        d = '0;
        if (s.pin_a != knob_last_a)
        begin
            // Two-detent mode judges both edges of A, one-detent mode only the falling one.
            if (settings.detent_mode || !s.pin_a)
            begin
                d.rotate_valid = 1'b1;
                d.rotate_dir   = s.pin_a ^ s.pin_b;
                d.scan_event   = (s.pin_a ^ s.pin_b) ? recd_pkg::EvCw : recd_pkg::EvCcw;
            end
            knob_last_a = s.pin_a;
            knob_last_b = s.pin_b;
        end
        if (!s.key_level)
        begin
            // A pressed key overrides the event code; in two-detent mode it hides the step.
            d.scan_event = recd_pkg::EvKey;
            if (settings.detent_mode)
            begin
                d.rotate_valid = 1'b0;
                d.rotate_dir   = 1'b0;
            end
            if (press_count < recd_pkg::PressMax)
                press_count = press_count + 1'b1;
            if (press_count == settings.debounce_ticks)
                short_seen = 1'b1;
            if (gap_count != 0 && gap_count <= settings.double_click_ticks)
                double_seen = recd_pkg::DblSeen;
            if (press_count == settings.long_press_ticks)
            begin
                long_seen  = 1'b1;
                short_seen = 1'b0;
            end
        end
        else if (press_count < settings.debounce_ticks)
        begin
            // Released before the debounce count: everything starts over.
            press_count = '0;
            gap_count   = '0;
            short_seen  = 1'b0;
            long_seen   = 1'b0;
            double_seen = recd_pkg::DblNone;
        end
        else if (short_seen)
        begin
            if (double_seen == recd_pkg::DblNone && gap_count < recd_pkg::GapMax)
                gap_count = gap_count + 1'b1;
            if (double_seen == recd_pkg::DblSeen && gap_count <= settings.double_click_ticks)
                double_seen = recd_pkg::DblDone;
            if (double_seen == recd_pkg::DblNone && gap_count > settings.double_click_ticks)
                short_seen = 1'b0;
        end
        d.short_click  = short_seen;
        d.long_click   = long_seen;
        d.double_state = double_seen;
        d.held_ticks   = press_count;
        return d;
    endfunction

    // Next pin levels: mostly a clean quadrature walk that sometimes turns back,
    // with the odd tick of random pin noise.
    function automatic recd_pkg::sample_t turn_knob(input logic press);
        recd_pkg::sample_t s;
        int unsigned       r;
        r = $urandom_range(99);
        if (r < 8)
        begin
            s.pin_a = 1'($urandom_range(1));
            s.pin_b = 1'($urandom_range(1));
        end
        else
        begin
            if (r < 13)
                knob_cw = !knob_cw;
            if (r < 55)
                knob_pos = knob_cw ? knob_pos + 2'd1 : knob_pos - 2'd1;
            s.pin_a = knob_pos[1];
            s.pin_b = knob_pos[1] ^ knob_pos[0];
        end
        s.key_level = !press;
        return s;
    endfunction

    function automatic string show(input decode_t d);
        return $sformatf("event=%0d rot=%0d dir=%0d short=%0d long=%0d double=%0d held=%0d",
                         d.scan_event, d.rotate_valid, d.rotate_dir, d.short_click,
                         d.long_click, d.double_state, d.held_ticks);
    endfunction

    // Offers one sample item, with random idle cycles ahead of it, and records the
    // expected result once the decoder has taken the item.
    task automatic offer_sample(input recd_pkg::sample_t s, input logic typed = 1'b0,
                                input decode_t want = '0);
        decode_t d;
        if (!steady)
        begin
            while ($urandom_range(99) < 14)
            begin
                pins_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pins_ch.valid     <= 1'b1;
        pins_ch.pin_a     <= s.pin_a;
        pins_ch.pin_b     <= s.pin_b;
        pins_ch.key_level <= s.key_level;
        @(posedge clk);
        while (!pins_ch.ready)
            @(posedge clk);
        d = decode_tick(s);
        pending_decodes.push_back(typed ? want : d);
    endtask

    // Register writes only happen with the decoder idle, so first wait for every
    // outstanding result to come back.
    task automatic write_reg(input logic [1:0] idx, input logic [recd_pkg::TickW-1:0] val);
        pins_ch.valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            recd_pkg::RegDetentMode:  settings.detent_mode        = val[0];
            recd_pkg::RegDebounce:    settings.debounce_ticks     = val;
            recd_pkg::RegLongPress:   settings.long_press_ticks   = val;
            recd_pkg::RegDoubleClick: settings.double_click_ticks = val;
            default: ;
        endcase
    endtask

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Safety net: a hung handshake ends the run here.
    initial
    begin : watchdog
        wait (cycle_count >= CycleLimit);
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: checks every accepted result item against the oldest expectation and
    // drives ready with random stalls, plus one long hold-off that backs the decoder up
    // until it refuses new sample items.
    initial
    begin : result_side
        decode_t     got;
        decode_t     want;
        int unsigned hold_left;
        bit          held_once;
        hold_left = 0;
        held_once = 1'b0;
        decode_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && decode_ch.valid && decode_ch.ready)
            begin
                results_seen++;
                got.scan_event   = decode_ch.scan_event;
                got.rotate_valid = decode_ch.rotate_valid;
                got.rotate_dir   = decode_ch.rotate_dir;
                got.short_click  = decode_ch.short_click;
                got.long_click   = decode_ch.long_click;
                got.double_state = decode_ch.double_state;
                got.held_ticks   = decode_ch.held_ticks;
                if (pending_decodes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: %s", show(got));
                end
                else
                begin
                    want = pending_decodes.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d mismatch\n  expected %s\n  actual   %s",
                                     results_seen, show(want), show(got));
                    end
                end
            end
            if (!held_once && hold_now)
            begin
                held_once = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                decode_ch.ready <= 1'b0;
            end
            else
                decode_ch.ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    // Sample side: reset, the directed script, random phases, then a final run with no
    // register writes during which the result side holds off for a long stretch.
    initial
    begin : sample_side
        int unsigned                random_items;
        int unsigned                phase_len;
        int unsigned                done;
        int unsigned                seg;
        logic                       pressed;
        logic [recd_pkg::TickW-1:0] deb;
        logic [recd_pkg::TickW-1:0] lng;
        logic [recd_pkg::TickW-1:0] dcl;

        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= recd_pkg::RegDetentMode;
        cfg_data          <= '0;
        pins_ch.valid     <= 1'b0;
        pins_ch.pin_a     <= 1'b0;
        pins_ch.pin_b     <= 1'b0;
        pins_ch.key_level <= 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == RowReg)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                offer_sample(script[i].pins, script[i].typed, script[i].want);
        end

        // Random phases. Each one clears the click logic with an out-of-range debounce
        // and a release, picks new settings (now and then at their extremes), and then
        // alternates press and release stretches sized around those settings, so that
        // short, long and double clicks actually happen. The knob keeps turning through
        // it all, and a few ticks flip the key to break the sequences.
        random_items = 0;
        while (random_items < RandomItems)
        begin
            write_reg(recd_pkg::RegDetentMode, 14'($urandom_range(1)));
            write_reg(recd_pkg::RegDebounce, 14'h3FFF);
            offer_sample(turn_knob(1'b0));
            random_items++;
            if ($urandom_range(7) == 0)
            begin
                deb = $urandom_range(1) ? 14'd1 : 14'd10000;
                case ($urandom_range(2))
                    0:       lng = 14'd1;
                    1:       lng = 14'd10000;
                    default: lng = 14'h3FFF;
                endcase
                case ($urandom_range(2))
                    0:       dcl = 14'd0;
                    1:       dcl = 14'd10000;
                    default: dcl = 14'h3FFF;
                endcase
            end
            else
            begin
                deb = 14'($urandom_range(1, 4));
                lng = deb + 14'($urandom_range(0, 12));
                dcl = 14'($urandom_range(0, 12));
            end
            write_reg(recd_pkg::RegDebounce, deb);
            write_reg(recd_pkg::RegLongPress, lng);
            write_reg(recd_pkg::RegDoubleClick, dcl);

            phase_len = $urandom_range(25, 60);
            done      = 0;
            pressed   = 1'b0;
            while (done < phase_len)
            begin
                pressed = !pressed;
                if (pressed)
                begin
                    if ($urandom_range(3) == 0)
                        seg = (lng > 37) ? $urandom_range(1, 40) : $urandom_range(1, lng + 3);
                    else
                        seg = (deb > 17) ? $urandom_range(1, 20) : $urandom_range(1, deb + 3);
                end
                else
                    seg = (dcl > 17) ? $urandom_range(1, 20) : $urandom_range(1, dcl + 3);
                repeat (seg)
                begin
                    // A stretch in the middle of the run goes without any idling.
                    steady = (random_items >= 400 && random_items < 650);
                    offer_sample(turn_knob(pressed ^ ($urandom_range(19) == 0)));
                    done++;
                    random_items++;
                end
            end
        end
        steady = 1'b0;

        // The sender keeps offering items with the last settings while the result side
        // holds off, so the decoder fills up and refuses further sample items.
        hold_now = 1'b1;
        repeat (FinalItems)
            offer_sample(turn_knob($urandom_range(3) == 0));

        pins_ch.valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        // Two register stages in the decoder; allow a little more for stray results.
        repeat (6) @(posedge clk);
        if (mismatches == 0 && pending_decodes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
